### hw/rtl/hktlp_pkg.sv
// Shared types, constants and the hash mixing tables of the hashed key table.
// Used by every module of the block but hktlp_ram; depends on nothing else.
`default_nettype none

package hktlp_pkg;

   // Table geometry; TABLE_DEPTH must be a power of two.
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // Field widths of the ports.
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;
   localparam int MASK_W   = 10;
   localparam int HASH_W   = 32;

   // Three hash kinds are kept: start index, check word A, check word B.
   localparam int NUM_KINDS = 3;
   localparam int KIND_W    = $clog2(NUM_KINDS);

   // One table entry: used flag, check word A, check word B.
   localparam int ENTRY_W = 1 + 2 * HASH_W;

   localparam logic [MASK_W-1:0] MASK_RESET    = 10'd1023;
   localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED7FED;
   localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEEEEEE;
   localparam logic [HASH_W-1:0] FOLD_INC      = 32'd3;

   // Generator that fills the mixing tables.
   localparam logic [31:0] LCG_SEED    = 32'h00100001;
   localparam logic [31:0] LCG_MUL     = 32'd125;
   localparam logic [31:0] LCG_INC     = 32'd3;
   localparam logic [31:0] LCG_MODULUS = 32'h002AAAAB;
   localparam logic [31:0] HALF_MASK   = 32'h0000FFFF;
   localparam int          LCG_ROWS    = 5;
   localparam int          MIX_COLS    = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_FIND  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_INSERTED  = 3'd0,
      RS_PRESENT   = 3'd1,
      RS_FOUND     = 3'd2,
      RS_NOT_FOUND = 3'd3,
      RS_FULL      = 3'd4,
      RS_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_HASH,
      MS_LAUNCH,
      MS_TABLE
   } main_state_type;

   typedef enum logic [1:0] {
      PS_CLEAR,
      PS_IDLE,
      PS_READ,
      PS_CHECK
   } probe_state_type;

   // Control from the sequencer to the hash unit.
   typedef struct packed {
      logic              go;
      logic              restart;
      logic [BYTE_W-1:0] key_byte;
   } hash_ctrl_type;

   // Status and running hashes of the hash unit.
   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] h0;
      logic [HASH_W-1:0] h1;
      logic [HASH_W-1:0] h2;
   } hash_out_type;

   // Table operation handed to the probe engine.
   typedef struct packed {
      command_type       op;
      logic [ADDR_W-1:0] start_pos;
      logic [ADDR_W-1:0] mask;
      logic [HASH_W-1:0] check_a;
      logic [HASH_W-1:0] check_b;
   } probe_req_type;

   // Outcome of a table operation.
   typedef struct packed {
      logic              done;
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } probe_rsp_type;

   typedef logic [HASH_W-1:0] mix_row_type [MIX_COLS];

   // Builds one row of the mixing table. Each column draws five words from the
   // generator and keeps only word number row; a word takes two successive draws.
   function automatic mix_row_type build_mix_row(input int row);
      mix_row_type tbl;
      logic [31:0] s;
      logic [31:0] hi;
      logic [31:0] lo;
      s = LCG_SEED;
      for (int col = 0; col < MIX_COLS; col++) begin
         for (int r = 0; r < LCG_ROWS; r++) begin
            s  = (s * LCG_MUL + LCG_INC) % LCG_MODULUS;
            hi = (s & HALF_MASK) << 16;
            s  = (s * LCG_MUL + LCG_INC) % LCG_MODULUS;
            lo = s & HALF_MASK;
            if (r == row) begin
               tbl[col] = hi | lo;
            end
         end
      end
      return tbl;
   endfunction

   localparam mix_row_type MIX_ROW0 = build_mix_row(0);
   localparam mix_row_type MIX_ROW1 = build_mix_row(1);
   localparam mix_row_type MIX_ROW2 = build_mix_row(2);

endpackage

`default_nettype wire

### hw/rtl/hktlp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the slot table of the hashed key table.
`default_nettype none

module hktlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/hktlp_hash.sv
// Shared hash unit: folds one key byte into the three running hashes, one
// hash kind at a time, first registering terms and then folding. Depends on hktlp_pkg.
`default_nettype none

module hktlp_hash (
   input  logic                     clock,
   input  logic                     reset,
   input  hktlp_pkg::hash_ctrl_type ctrl,
   output hktlp_pkg::hash_out_type  result
);
   import hktlp_pkg::*;

   localparam logic [KIND_W-1:0] KIND_FIRST = '0;
   localparam logic [KIND_W-1:0] KIND_LAST  = KIND_W'(NUM_KINDS - 1);
   localparam logic [BYTE_W-1:0] LOWER_A    = 8'h61;
   localparam logic [BYTE_W-1:0] LOWER_Z    = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_SHIFT = 8'h20;

   logic [HASH_W-1:0] one_ff [NUM_KINDS];
   logic [HASH_W-1:0] two_ff [NUM_KINDS];
   logic [KIND_W-1:0] sel_ff, sel_in;
   logic              phase_ff, phase_in;
   logic              active_ff, active_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [HASH_W-1:0] mix_ff, mix_in;
   logic [HASH_W-1:0] sum_ff, sum_in;
   logic [HASH_W-1:0] pre_ff, pre_in;
   logic [HASH_W-1:0] mix_word;
   logic [HASH_W-1:0] one_new;
   logic [HASH_W-1:0] two_new;
   logic              fold_step;
   logic              last_step;

   // Upper-case ASCII letters before folding.
   always_comb begin
      if (ctrl.key_byte >= LOWER_A && ctrl.key_byte <= LOWER_Z) begin
         byte_in = ctrl.key_byte - CASE_SHIFT;
      end else begin
         byte_in = ctrl.key_byte;
      end
   end

   // Mixing word for the current hash kind.
   always_comb begin
      case (sel_ff)
         2'd0:    mix_word = MIX_ROW0[byte_ff];
         2'd1:    mix_word = MIX_ROW1[byte_ff];
         default: mix_word = MIX_ROW2[byte_ff];
      endcase
   end

   // First phase of a kind: table word, seed sum and the byte-dependent term.
   assign mix_in = mix_word;
   assign sum_in = one_ff[sel_ff] + two_ff[sel_ff];
   assign pre_in = two_ff[sel_ff] + (two_ff[sel_ff] << 5) + HASH_W'(byte_ff) + FOLD_INC;

   // Second phase of a kind: new seed pair.
   assign one_new = mix_ff ^ sum_ff;
   assign two_new = one_new + pre_ff;

   assign fold_step = active_ff && phase_ff;
   assign last_step = fold_step && (sel_ff == KIND_LAST);

   // Small sequencer over the three kinds.
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      sel_in    = sel_ff;
      if (ctrl.go) begin
         active_in = 1'b1;
         phase_in  = 1'b0;
         sel_in    = KIND_FIRST;
      end else if (active_ff) begin
         phase_in = ~phase_ff;
         if (phase_ff) begin
            if (sel_ff == KIND_LAST) begin
               active_in = 1'b0;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
         sel_ff    <= KIND_FIRST;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         sel_ff    <= sel_in;
      end
   end

   // Datapath registers of the shared unit.
   always_ff @(posedge clock) begin
      if (ctrl.go) begin
         byte_ff <= byte_in;
      end
      if (active_ff && !phase_ff) begin
         mix_ff <= mix_in;
         sum_ff <= sum_in;
         pre_ff <= pre_in;
      end
   end

   // Running seeds; restart returns them to their start values.
   always_ff @(posedge clock) begin
      if (reset || ctrl.restart) begin
         for (int k = 0; k < NUM_KINDS; k++) begin
            one_ff[k] <= SEED_ONE_INIT;
            two_ff[k] <= SEED_TWO_INIT;
         end
      end else if (fold_step) begin
         one_ff[sel_ff] <= one_new;
         two_ff[sel_ff] <= two_new;
      end
   end

   assign result.done = last_step;
   assign result.h0   = one_ff[0];
   assign result.h1   = one_ff[1];
   assign result.h2   = one_ff[2];

endmodule

`default_nettype wire

### hw/rtl/hktlp_probe.sv
// Probe engine: clears the slot table and runs linear-probe inserts and
// lookups against it. Depends on hktlp_pkg and hktlp_ram.
`default_nettype none

module hktlp_probe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  hktlp_pkg::probe_req_type req,
   output hktlp_pkg::probe_rsp_type rsp,
   output logic                     busy
);
   import hktlp_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(TABLE_DEPTH - 1);
   localparam int                USED_BIT = ENTRY_W - 1;

   probe_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] mask_ff, mask_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   command_type       op_ff, op_in;
   logic [HASH_W-1:0] check_a_ff, check_a_in;
   logic [HASH_W-1:0] check_b_ff, check_b_in;
   logic              report_ff, report_in;

   logic               ram_wr_en;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               rd_used;
   logic               rd_hit;
   logic [ADDR_W-1:0]  next_pos;
   logic               finish;

   hktlp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_used  = ram_rd_data[USED_BIT];
   assign rd_hit   = (ram_rd_data[2*HASH_W-1:HASH_W] == check_a_ff) &&
                     (ram_rd_data[HASH_W-1:0] == check_b_ff);
   assign next_pos = (pos_ff + 1'b1) & mask_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_CLEAR: begin
            if (pos_ff == LAST_POS) begin
               state_in = PS_IDLE;
            end
         end
         PS_IDLE: begin
            if (go) begin
               state_in = (req.op == CMD_CLEAR) ? PS_CLEAR : PS_READ;
            end
         end
         PS_READ: begin
            state_in = PS_CHECK;
         end
         PS_CHECK: begin
            state_in = finish ? PS_IDLE : PS_READ;
         end
         default: begin
            state_in = PS_IDLE;
         end
      endcase
   end

   // Outputs, table access and datapath updates.
   always_comb begin
      pos_in      = pos_ff;
      start_in    = start_ff;
      mask_in     = mask_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      check_a_in  = check_a_ff;
      check_b_in  = check_b_ff;
      report_in   = report_ff;
      ram_wr_en   = 1'b0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      finish      = 1'b0;
      rsp.done    = 1'b0;
      rsp.status  = RS_CLEARED;
      rsp.slot    = '0;
      case (state_ff)
         PS_CLEAR: begin
            // One entry a cycle back to empty.
            ram_wr_en = 1'b1;
            pos_in    = pos_ff + 1'b1;
            if (pos_ff == LAST_POS) begin
               rsp.done  = report_ff;
               report_in = 1'b0;
            end
         end
         PS_IDLE: begin
            if (go) begin
               op_in      = req.op;
               start_in   = req.start_pos;
               mask_in    = req.mask;
               check_a_in = req.check_a;
               check_b_in = req.check_b;
               count_in   = '0;
               if (req.op == CMD_CLEAR) begin
                  pos_in    = '0;
                  report_in = 1'b1;
               end else begin
                  pos_in = req.start_pos;
               end
            end
         end
         PS_READ: begin
            ram_rd_en = 1'b1;
         end
         PS_CHECK: begin
            if (!rd_used) begin
               // Empty slot ends the probe: insert here or report a miss.
               finish   = 1'b1;
               rsp.done = 1'b1;
               if (op_ff == CMD_ADD) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, check_a_ff, check_b_ff};
                  rsp.status  = RS_INSERTED;
                  rsp.slot    = SLOT_W'(pos_ff);
               end else begin
                  rsp.status = RS_NOT_FOUND;
               end
            end else if (rd_hit) begin
               finish     = 1'b1;
               rsp.done   = 1'b1;
               rsp.status = (op_ff == CMD_ADD) ? RS_PRESENT : RS_FOUND;
               rsp.slot   = SLOT_W'(pos_ff);
            end else if (next_pos == start_ff || count_ff == LAST_POS) begin
               // Wrapped around or probed every slot.
               finish     = 1'b1;
               rsp.done   = 1'b1;
               rsp.status = (op_ff == CMD_ADD) ? RS_FULL : RS_NOT_FOUND;
            end else begin
               pos_in   = next_pos;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= PS_CLEAR;
         pos_ff    <= '0;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         report_ff <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      mask_ff    <= mask_in;
      count_ff   <= count_in;
      op_ff      <= op_in;
      check_a_ff <= check_a_in;
      check_b_ff <= check_b_in;
   end

   assign busy = (state_ff != PS_IDLE);

   // A probe never overwrites an occupied slot.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PS_CHECK && ram_wr_en) |-> !rd_used)
      else $error("probe wrote over an occupied slot");

   // Misses, full tables and clears report slot zero.
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.done && (rsp.status == RS_NOT_FOUND || rsp.status == RS_FULL ||
                    rsp.status == RS_CLEARED)) |-> (rsp.slot == '0))
      else $error("nonzero slot on a result without a slot");

endmodule

`default_nettype wire

### hw/rtl/hashed_key_table_linear_probe.sv
// Top level of the hashed key table with linear probing.
// Depends on hktlp_pkg, hktlp_hash and hktlp_probe.
//
// Usage:
//   An item (command, key byte, last-byte flag) is taken when start is high
//   and busy is low. Key bytes are folded into three running hashes; a zero
//   byte is skipped. The item that carries the last byte adds or looks up the
//   key; a clear command empties the table. Command code 3 is dropped.
//   Each result is shown on rsp_status/rsp_slot for one cycle with rsp_valid;
//   the receiver cannot stall, so nothing is held back.
//   The shared hash unit folds a non-zero key byte into the 3 hash kinds in
//   turn, a register and a fold phase each, with busy high. A last byte then
//   passes a launch state and a read and a compare per probed slot (one table
//   read port); its result appears in the cycle after the final probe. A clear
//   walks the table one slot a cycle. Reset: the table is cleared by the same
//   pass, busy stays high after reset until that pass ends, and index_mask
//   returns to 1023. index_mask is written via csr_valid/csr_ready; the user
//   is to do so only while the block is idle; the block leaves this unchecked.
`default_nettype none

module hashed_key_table_linear_probe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [hktlp_pkg::CMD_W-1:0]     req_command,
   input  logic [hktlp_pkg::BYTE_W-1:0]    req_key_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   output logic [hktlp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [hktlp_pkg::SLOT_W-1:0]    rsp_slot,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hktlp_pkg::MASK_W-1:0]    csr_index_mask
);
   import hktlp_pkg::*;

   main_state_type    state_ff, state_in;
   command_type       cmd_ff, cmd_in;
   logic              last_ff, last_in;
   logic [MASK_W-1:0] mask_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic              accept;
   command_type       req_cmd;
   logic [ADDR_W-1:0] mask_eff;
   hash_ctrl_type     hash_ctrl;
   hash_out_type      hash_out;
   logic              probe_go;
   probe_req_type     probe_req;
   probe_rsp_type     probe_rsp;
   logic              probe_busy;

   hktlp_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (hash_ctrl),
      .result (hash_out)
   );

   hktlp_probe u_probe (
      .clock (clock),
      .reset (reset),
      .go    (probe_go),
      .req   (probe_req),
      .rsp   (probe_rsp),
      .busy  (probe_busy)
   );

   assign req_cmd  = command_type'(req_command);
   assign busy     = reset || (state_ff != MS_IDLE) || probe_busy;
   assign accept   = start && !busy;
   assign mask_eff = ADDR_W'(mask_ff);

   // Configuration register.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         mask_ff <= csr_index_mask;
      end
   end

   // Next state of the item sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MS_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CLEAR) begin
                  state_in = MS_LAUNCH;
               end else if (req_cmd == CMD_NONE) begin
                  state_in = MS_IDLE;
               end else if (req_key_byte != '0) begin
                  state_in = MS_HASH;
               end else if (req_last_byte) begin
                  state_in = MS_LAUNCH;
               end
            end
         end
         MS_HASH: begin
            if (hash_out.done) begin
               state_in = last_ff ? MS_LAUNCH : MS_IDLE;
            end
         end
         MS_LAUNCH: begin
            state_in = MS_TABLE;
         end
         MS_TABLE: begin
            if (probe_rsp.done) begin
               state_in = MS_IDLE;
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   // Sequencer outputs: hash unit control and table launch.
   always_comb begin
      cmd_in  = cmd_ff;
      last_in = last_ff;
      if (accept) begin
         cmd_in  = req_cmd;
         last_in = req_last_byte;
      end
      hash_ctrl.go       = accept && (req_cmd == CMD_ADD || req_cmd == CMD_FIND) &&
                           (req_key_byte != '0);
      hash_ctrl.key_byte = req_key_byte;
      hash_ctrl.restart  = (state_ff == MS_LAUNCH);
      probe_go            = (state_ff == MS_LAUNCH);
      probe_req.op        = cmd_ff;
      probe_req.start_pos = ADDR_W'(hash_out.h0) & mask_eff;
      probe_req.mask      = mask_eff;
      probe_req.check_a   = hash_out.h1;
      probe_req.check_b   = hash_out.h2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= probe_rsp.done;
      end
   end

   // Item fields and result payload.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      last_ff <= last_in;
      if (probe_rsp.done) begin
         rsp_status_ff <= probe_rsp.status;
         rsp_slot_ff   <= probe_rsp.slot;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   // A result only follows a table operation.
   a_rsp_after_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == MS_TABLE))
      else $error("result without a table operation");

   // A dropped command leaves the block idle.
   a_drop_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_NONE) |=> !busy)
      else $error("unused command made the block busy");

   // The probe engine is idle while key bytes are folded.
   a_hash_probe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MS_HASH) |-> !probe_busy)
      else $error("probe engine active during hashing");

endmodule

`default_nettype wire
